@@ design/lswaq_pkg.sv @@
package lswaq_pkg;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 10;

	localparam logic [CFG_IDX_W-1:0] CFG_FULL_SCALE   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_STABLE_COUNT = 1'b1;

	localparam int FS_W    = 10;
	localparam int STAB_W  = 3;
	localparam int LEVEL_W = 7;
	// 1023 * 100 fits in 17 bits
	localparam int PROD_W  = 17;

	localparam logic [FS_W-1:0]    FULL_SCALE_RST   = 10'd800;
	localparam logic [STAB_W-1:0]  STABLE_COUNT_RST = 3'd5;
	localparam logic [LEVEL_W-1:0] PCT_FULL         = 7'd100;
	localparam logic [LEVEL_W-1:0] STEP_TEN         = 7'd10;
	localparam logic [LEVEL_W-1:0] STEP_HALF        = 7'd5;
	// floor(x / 10) == (x * 205) >> 11 for x up to 100
	localparam logic [14:0]        RECIP_TEN        = 15'd205;

	localparam logic DIV_SEL_AVG = 1'b0;
	localparam logic DIV_SEL_PCT = 1'b1;

	typedef struct packed {
		logic load;
		logic upd;
		logic div_start;
		logic div_sel;
		logic scale;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic out_busy;
	} sts_t;

	function automatic logic [LEVEL_W-1:0] quantize_five(input logic [LEVEL_W-1:0] pct);
		logic [14:0]        prod;
		logic [3:0]         tens;
		logic [LEVEL_W-1:0] tens_x10;
		logic [LEVEL_W-1:0] ones;
		logic [LEVEL_W-1:0] result;
		prod     = {8'd0, pct} * RECIP_TEN;
		tens     = prod[14:11];
		tens_x10 = {3'd0, tens} * STEP_TEN;
		ones     = pct - tens_x10;
		if (ones > STEP_HALF) begin
			result = tens_x10 + STEP_HALF;
		end else begin
			result = tens_x10;
		end
		return result;
	endfunction

endpackage

@@ design/lswaq_ram.sv @@
module lswaq_ram #(
	parameter int WIDTH = 10,
	parameter int DEPTH = 8
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ design/lswaq_div.sv @@
module lswaq_div #(
	parameter int DIVIDEND_W = 17,
	parameter int DIVISOR_W  = 10
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [DIVIDEND_W-1:0] dividend,
	input  logic [DIVISOR_W-1:0]  divisor,
	output logic [DIVIDEND_W-1:0] quotient,
	output logic                  done
);

	localparam int CNT_W = $clog2(DIVIDEND_W + 1);

	logic [DIVIDEND_W-1:0] quo_q;
	logic [DIVISOR_W-1:0]  rem_q;
	logic [DIVISOR_W-1:0]  dvs_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  busy_q;
	logic                  done_q;

	logic [DIVISOR_W:0]    rem_sh;
	logic [DIVISOR_W:0]    rem_nx;
	logic                  ge;

	// restoring divide, one quotient bit per cycle
	always_comb begin
		rem_sh = {rem_q, quo_q[DIVIDEND_W-1]};
		ge     = rem_sh >= {1'b0, dvs_q};
		rem_nx = ge ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(DIVIDEND_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIVIDEND_W-2:0], ge};
			rem_q <= rem_nx[DIVISOR_W-1:0];
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

endmodule

@@ design/lswaq_ctrl.sv @@
module lswaq_ctrl
	import lswaq_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_UPD   = 3'd1;
	localparam logic [2:0] ST_DIV1  = 3'd2;
	localparam logic [2:0] ST_WAIT1 = 3'd3;
	localparam logic [2:0] ST_SCALE = 3'd4;
	localparam logic [2:0] ST_DIV2  = 3'd5;
	localparam logic [2:0] ST_WAIT2 = 3'd6;
	localparam logic [2:0] ST_FIN   = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_nx;

	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_nx = ST_UPD;
				end
			end
			ST_UPD: begin
				cmd.upd  = 1'b1;
				state_nx = ST_DIV1;
			end
			ST_DIV1: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DIV_SEL_AVG;
				state_nx      = ST_WAIT1;
			end
			ST_WAIT1: begin
				if (sts.div_done) begin
					state_nx = ST_SCALE;
				end
			end
			ST_SCALE: begin
				cmd.scale = 1'b1;
				state_nx  = ST_DIV2;
			end
			ST_DIV2: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DIV_SEL_PCT;
				state_nx      = ST_WAIT2;
			end
			ST_WAIT2: begin
				if (sts.div_done) begin
					state_nx = ST_FIN;
				end
			end
			ST_FIN: begin
				// hold while the previous result has not been taken
				if (!sts.out_busy) begin
					cmd.finish = 1'b1;
					state_nx   = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

endmodule

@@ design/lswaq_datapath.sv @@
module lswaq_datapath
	import lswaq_pkg::*;
#(
	parameter int WINDOW_DEPTH = 8,
	parameter int SAMPLE_BITS  = 10
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cmd_t                  cmd,
	output sts_t                  sts,
	input  logic [9:0]            in_sample,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [LEVEL_W-1:0]    out_level,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	localparam int SW    = SAMPLE_BITS < 10 ? SAMPLE_BITS : 10;
	localparam int AW    = WINDOW_DEPTH > 1 ? $clog2(WINDOW_DEPTH) : 1;
	localparam int CW    = $clog2(WINDOW_DEPTH + 1);
	localparam int SUM_W = SW + CW;
	localparam int DIV_W = SUM_W > PROD_W ? SUM_W : PROD_W;
	localparam int DVS_W = CW > FS_W ? CW : FS_W;

	logic [FS_W-1:0]    fs_q;
	logic [STAB_W-1:0]  sc_q;
	logic [SW-1:0]      sample_q;
	logic [AW-1:0]      ptr_q;
	logic               full_q;
	logic [SUM_W-1:0]   sum_q;
	logic [CW-1:0]      cnt_q;
	logic [PROD_W-1:0]  prod_q;
	logic [LEVEL_W-1:0] reported_q;
	logic [STAB_W-1:0]  stab_q;
	logic               out_valid_q;
	logic [LEVEL_W-1:0] out_data_q;

	logic [SW-1:0]      rd_data;
	logic [SW-1:0]      oldest;
	logic               wrap;
	logic [DIV_W-1:0]   div_dividend;
	logic [DVS_W-1:0]   div_divisor;
	logic [DIV_W-1:0]   quotient;
	logic               div_done;
	logic [FS_W-1:0]    avg_c;
	logic [LEVEL_W-1:0] pct;
	logic [LEVEL_W-1:0] level;
	logic [STAB_W-1:0]  stab_inc;
	logic               differ;
	logic               report;

	lswaq_ram #(
		.WIDTH (SW),
		.DEPTH (WINDOW_DEPTH)
	) u_window (
		.clk   (clk),
		.we    (cmd.upd),
		.waddr (ptr_q),
		.wdata (sample_q),
		.raddr (ptr_q),
		.rdata (rd_data)
	);

	lswaq_div #(
		.DIVIDEND_W (DIV_W),
		.DIVISOR_W  (DVS_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.quotient (quotient),
		.done     (div_done)
	);

	// slots not yet written since reset read as empty
	assign oldest = full_q ? rd_data : '0;
	assign wrap   = ptr_q == AW'(WINDOW_DEPTH - 1);

	always_comb begin
		if (cmd.div_sel == DIV_SEL_PCT) begin
			div_dividend = DIV_W'(prod_q);
			div_divisor  = DVS_W'(fs_q);
		end else begin
			div_dividend = DIV_W'(sum_q);
			div_divisor  = DVS_W'(cnt_q);
		end
	end

	always_comb begin
		if (cnt_q == '0) begin
			avg_c = '0;
		end else if (quotient > DIV_W'(fs_q)) begin
			avg_c = fs_q;
		end else begin
			avg_c = quotient[FS_W-1:0];
		end
		pct      = (fs_q == '0) ? '0 : quotient[LEVEL_W-1:0];
		level    = quantize_five(pct);
		differ   = level != reported_q;
		stab_inc = stab_q + STAB_W'(1);
		report   = differ && (stab_inc >= sc_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fs_q        <= FULL_SCALE_RST;
			sc_q        <= STABLE_COUNT_RST;
			ptr_q       <= '0;
			full_q      <= 1'b0;
			sum_q       <= '0;
			cnt_q       <= '0;
			reported_q  <= '0;
			stab_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_FULL_SCALE:   fs_q <= cfg_wdata[FS_W-1:0];
					CFG_STABLE_COUNT: sc_q <= cfg_wdata[STAB_W-1:0];
					default: begin
					end
				endcase
			end
			// a new level only lands once the pending one is taken or gone
			if (cmd.finish && report) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.upd) begin
				sum_q  <= sum_q + SUM_W'(sample_q) - SUM_W'(oldest);
				cnt_q  <= cnt_q + CW'(sample_q != '0) - CW'(oldest != '0);
				ptr_q  <= wrap ? '0 : ptr_q + AW'(1);
				if (wrap) begin
					full_q <= 1'b1;
				end
			end
			if (cmd.finish && differ) begin
				if (report) begin
					stab_q      <= '0;
					reported_q  <= level;
				end else begin
					stab_q <= stab_inc;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sample_q <= in_sample[SW-1:0];
		end
		if (cmd.scale) begin
			prod_q <= PROD_W'(avg_c) * PROD_W'(PCT_FULL);
		end
		if (cmd.finish && report) begin
			out_data_q <= level;
		end
	end

	assign sts.div_done = div_done;
	assign sts.out_busy = out_valid_q && !out_ready;
	assign out_valid    = out_valid_q;
	assign out_level    = out_data_q;

	a_sum_cnt_agree: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == '0) == (sum_q == '0))
		else $error("window sum and nonzero count disagree");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(WINDOW_DEPTH))
		else $error("nonzero count beyond window depth");

	a_out_is_reported: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_data_q == reported_q) && (out_data_q <= PCT_FULL))
		else $error("pending level does not match the stored level");

	a_stab_bound: assert property (@(posedge clk) disable iff (!arst_n)
		stab_q != 3'd7)
		else $error("stabiliser counter held at a value that must report");

endmodule

@@ design/level_sensor_window_average_quantizer.sv @@
// level sensor window average quantiser
// s_axis carries one pressure sample per transaction (tdata[9:0], zero means no reading);
// m_axis carries a newly reported fill level in percent (tdata[6:0]), 0..100 in steps of 5.
// most samples give no result; one is given only when a differing level has been seen
// often enough since the last report, not necessarily in a row, to reach the stabiliser count.
// cfg_we/cfg_index/cfg_wdata write full_scale (index 0) and stable_count (index 1);
// write them only while no sample is in flight.
// one sample is worked on at a time: s_axis_tready is high only when the block is idle.
// a sample's pace is set by the shared serial divider, which runs once for the window
// average and once for the percentage; DIV_W is the wider of the window sum and 17 bits.
// the window lives in a small ram with a running sum and nonzero count, so the
// per-sample cost does not grow with the window depth.
// reset empties the window at once (a fill flag masks unwritten slots), clears the
// reported level and stabiliser counter, and loads full_scale 800 and stable_count 5.
// the result sits in an output register; a new sample is taken while it waits, and the
// block only holds at the end of the next sample if that result is still not taken.
module level_sensor_window_average_quantizer
	import lswaq_pkg::*;
#(
	parameter int WINDOW_DEPTH = 8,
	parameter int SAMPLE_BITS  = 10
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [15:0]           s_axis_tdata,  // [9:0] sample
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [7:0]            m_axis_tdata,  // [6:0] level_percent
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	cmd_t               cmd;
	sts_t               sts;
	logic [LEVEL_W-1:0] out_level;

	lswaq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	lswaq_datapath #(
		.WINDOW_DEPTH (WINDOW_DEPTH),
		.SAMPLE_BITS  (SAMPLE_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_sample (s_axis_tdata[9:0]),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_level (out_level),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	assign m_axis_tdata = {1'b0, out_level};

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
	import lswaq_pkg::*;

	logic                  clk;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [15:0]           s_axis_tdata;  // [9:0] sample
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [7:0]            m_axis_tdata;  // [6:0] level_percent
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	// predictor state
	logic [9:0]         win_samples [8];
	logic [LEVEL_W-1:0] shown_level;
	logic [STAB_W-1:0]  stab_cnt;
	logic [FS_W-1:0]    fs_reg;
	logic [STAB_W-1:0]  sc_reg;

	logic [LEVEL_W-1:0] level_queue [$];
	int                 error_count;
	bit                 gaps_on;

	level_sensor_window_average_quantizer dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#25_000_000;
		$display("testbench failed");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t: %s", $time, msg);
		error_count++;
	endtask

	// mean of the nonzero window entries, clamped, scaled and stepped to fives
	function automatic logic [LEVEL_W-1:0] window_level();
		int unsigned total, valid, avg, pct;
		total = 0;
		valid = 0;
		avg   = 0;
		for (int k = 0; k < 8; k++) begin
			if (win_samples[k] != 0) begin
				total += win_samples[k];
				valid++;
			end
		end
		if (valid != 0) begin
			avg = total / valid;
		end
		if (fs_reg == 0) begin
			pct = 0;
		end else begin
			if (avg > fs_reg) begin
				avg = fs_reg;
			end
			pct = (avg * 100) / fs_reg;
		end
		if (pct % 10 > 5) begin
			return LEVEL_W'((pct / 10) * 10 + 5);
		end
		return LEVEL_W'((pct / 10) * 10);
	endfunction

	task automatic predict_level(input logic [9:0] value);
		logic [LEVEL_W-1:0] lvl;
		for (int k = 7; k > 0; k--) begin
			win_samples[k] = win_samples[k-1];
		end
		win_samples[0] = value;
		lvl = window_level();
		if (lvl != shown_level) begin
			stab_cnt = stab_cnt + 1'b1;
			if (stab_cnt >= sc_reg) begin
				stab_cnt    = '0;
				shown_level = lvl;
				level_queue.push_back(lvl);
			end
		end
	endtask

	function automatic int pick_gap();
		int r;
		if (!gaps_on) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end else if (r < 90) begin
			return $urandom_range(1, 3);
		end else if (r < 97) begin
			return $urandom_range(4, 10);
		end
		return $urandom_range(20, 60);
	endfunction

	task automatic send_sample(input logic [9:0] value);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {6'd0, value};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		predict_level(value);
	endtask

	task automatic pause_until_drained();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (level_queue.size() != 0) @(posedge clk);
	endtask

	// a sample may still be in work with no level due, so allow its latency too
	task automatic wait_block_idle();
		pause_until_drained();
		repeat (60) @(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		if (idx == CFG_FULL_SCALE) begin
			fs_reg = value[FS_W-1:0];
		end else begin
			sc_reg = value[STAB_W-1:0];
		end
	endtask

	task automatic apply_settings(input int fs, input int sc);
		wait_block_idle();
		write_register(CFG_FULL_SCALE, CFG_DATA_W'(fs));
		write_register(CFG_STABLE_COUNT, CFG_DATA_W'(sc));
	endtask

	task automatic test_reset_defaults();
		// empty window after reset gives level 0, same as the reset level
		send_sample(10'd0);
		send_sample(10'd0);
		// full-scale readings clamp at 800 and report 100 on the fifth
		repeat (5) send_sample(10'd1023);
		send_sample(10'd512);
	endtask

	task automatic test_special_cases();
		// zero full scale gives 0 percent; zero stable count reports at once
		apply_settings(0, 0);
		send_sample(10'd700);
		send_sample(10'd300);
		apply_settings(1023, 0);
		send_sample(10'd1023);
	endtask

	task automatic test_config_extremes();
		apply_settings(1, 7);
		repeat (7) send_sample(10'd1);
		apply_settings(1023, 1);
		send_sample(10'd1023);
		send_sample(10'd612);
		send_sample(10'd513);
	endtask

	task automatic run_random_levels(input int n_items);
		int sent, run_len, mode, target, top, val;
		sent = 0;
		while (sent < n_items) begin
			mode    = $urandom_range(0, 9);
			run_len = (mode == 8) ? $urandom_range(8, 12) : $urandom_range(3, 16);
			top     = (fs_reg == 0) ? 1023 : fs_reg + fs_reg / 8 + 1;
			if (top > 1023) begin
				top = 1023;
			end
			target = $urandom_range(1, top);
			for (int k = 0; k < run_len && sent < n_items; k++) begin
				if (mode <= 6) begin
					// steady level with a little jitter and the odd missing reading
					val = target + int'($urandom_range(0, 16)) - 8;
					if (val < 0) begin
						val = 0;
					end else if (val > 1023) begin
						val = 1023;
					end
					if ($urandom_range(0, 9) == 0) begin
						val = 0;
					end
				end else if (mode == 7) begin
					val = $urandom_range(0, 1023);
				end else if (mode == 8) begin
					val = 0;
				end else begin
					val = $urandom_range(0, 1) ? 1023 : 1;
				end
				send_sample(val[9:0]);
				sent++;
			end
		end
	endtask

	task automatic test_config_sweep();
		gaps_on = 1'b1;
		apply_settings(1023, 7);
		run_random_levels(240);
		apply_settings(1, 1);
		run_random_levels(240);
		// back-to-back transactions on both sides
		gaps_on = 1'b0;
		apply_settings(800, 5);
		run_random_levels(240);
		gaps_on = 1'b1;
		apply_settings(100, 3);
		run_random_levels(240);
		repeat (2) begin
			apply_settings($urandom_range(1, 1023), $urandom_range(1, 7));
			run_random_levels(240);
		end
	endtask

	task automatic test_drain_pause();
		apply_settings(600, 2);
		repeat (6) begin
			run_random_levels(20);
			pause_until_drained();
		end
	endtask

	// level monitor with random back-pressure
	always @(posedge clk) begin : level_monitor
		logic [LEVEL_W-1:0] want;
		int                 stall_left;
		int                 r;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (level_queue.size() == 0) begin
				report_mismatch($sformatf("level %0d with none due", m_axis_tdata[6:0]));
			end else begin
				want = level_queue.pop_front();
				if (m_axis_tdata[6:0] !== want) begin
					report_mismatch($sformatf("level_percent got %0d want %0d",
						m_axis_tdata[6:0], want));
				end
			end
		end
		if (stall_left > 0) begin
			stall_left--;
			m_axis_tready <= 1'b0;
		end else if (!gaps_on) begin
			m_axis_tready <= 1'b1;
		end else begin
			r = $urandom_range(0, 99);
			if (r < 12) begin
				stall_left = $urandom_range(0, 2);
				m_axis_tready <= 1'b0;
			end else if (r < 15) begin
				stall_left = $urandom_range(20, 60);
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	initial begin
		error_count   = 0;
		gaps_on       = 1'b1;
		shown_level   = '0;
		stab_cnt      = '0;
		fs_reg        = FULL_SCALE_RST;
		sc_reg        = STABLE_COUNT_RST;
		for (int k = 0; k < 8; k++) begin
			win_samples[k] = '0;
		end
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		m_axis_tready <= 1'b0;
		cfg_we        <= 1'b0;
		cfg_index     <= CFG_FULL_SCALE;
		cfg_wdata     <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_special_cases();
		test_config_extremes();
		test_config_sweep();
		test_drain_pause();

		pause_until_drained();
		repeat (100) @(posedge clk);
		if (error_count == 0) begin
			$display("testbench passed");
		end else begin
			$display("testbench failed");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
design/lswaq_pkg.sv
design/lswaq_ram.sv
design/lswaq_div.sv
design/lswaq_ctrl.sv
design/lswaq_datapath.sv
design/level_sensor_window_average_quantizer.sv
tb/testbench.sv
